[hw/rtl/csi2_pkg.sv]
// -----------------------------------------------------------------------------
// csi2_pkg - shared definitions of the packet frame extractor
// Field widths, result kind codes, register indexes and register reset values.
// -----------------------------------------------------------------------------
package csi2_pkg;

   // Field widths
   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 2;
   localparam int FRAME_ID_W = 16;
   localparam int COUNT_W    = 17;
   localparam int CSR_IDX_W  = 2;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ABANDON  = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_END   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RAW8        = 2'd2;

   // Register reset values
   localparam logic [BYTE_W-1:0] FRAME_START_RST = 8'd0;
   localparam logic [BYTE_W-1:0] FRAME_END_RST   = 8'd1;
   localparam logic [BYTE_W-1:0] RAW8_RST        = 8'd42;

   // Header byte positions
   localparam logic [1:0] HDR_TYPE  = 2'd0;
   localparam logic [1:0] HDR_WC_HI = 2'd1;
   localparam logic [1:0] HDR_WC_LO = 2'd2;
   localparam logic [1:0] HDR_ECC   = 2'd3;

   // Trailing CRC bytes of a long packet
   localparam logic [COUNT_W-1:0] CRC_BYTES = 17'd2;

   // Step of the byte counter
   localparam logic [COUNT_W-1:0] COUNT_ONE = 17'd1;

   // One result entry
   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [FRAME_ID_W-1:0] frame_id;
      logic [BYTE_W-1:0]     payload;
   } result_type;

endpackage

[hw/rtl/csi2_packet_frame_extractor_top.sv]
// -----------------------------------------------------------------------------
// csi2_packet_frame_extractor_top - packet deframer for a CSI-2 style stream
// Parses 4-byte packet headers, tracks frames and streams kept RAW8 payload.
// -----------------------------------------------------------------------------
// The block takes one stream byte per request and accepts one in every cycle
// with ready high: header parsing, payload counting and frame tracking are one
// pass of combinational logic from the parser state registers to the result
// register. Each request yields at most one result: a payload byte (RAW8
// packet inside an open frame), a frame complete at frame end, or a frame
// abandoned when a new frame start or the buffer end (tlast) finds a frame
// still open. An output register and a skid register decouple the two sides, so
// ready only drops after two results are held back. The user must write the type
// codes through the csr port only while the block is idle; it is not enforced.
module csi2_packet_frame_extractor_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   input  logic        req_tlast,   // buffer_end
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] payload_byte, [23:8] frame_number
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   // configuration write port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   // Configuration registers
   logic [csi2_pkg::BYTE_W-1:0] frame_start_type_ff;
   logic [csi2_pkg::BYTE_W-1:0] frame_end_type_ff;
   logic [csi2_pkg::BYTE_W-1:0] raw8_type_ff;

   // Parser state
   logic [1:0]                      hdr_pos_ff, hdr_pos_in;
   logic [csi2_pkg::BYTE_W-1:0]     pkt_type_ff, pkt_type_in;
   logic [csi2_pkg::BYTE_W-1:0]     wc_high_ff, wc_high_in;
   logic [csi2_pkg::COUNT_W-1:0]    bytes_left_ff, bytes_left_in;
   logic                            in_frame_ff, in_frame_in;
   logic [csi2_pkg::FRAME_ID_W-1:0] frame_id_ff, frame_id_in;

   // Result staging
   logic                 out_valid_ff, skid_valid_ff;
   csi2_pkg::result_type out_ff, skid_ff;
   csi2_pkg::result_type res;
   logic                 res_have;

   logic [csi2_pkg::BYTE_W-1:0]     in_byte;
   logic [csi2_pkg::FRAME_ID_W-1:0] word_count;
   logic                            accept, pop;

   assign in_byte    = req_tdata;
   assign word_count = bytes_left_ff[csi2_pkg::FRAME_ID_W-1:0];
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_start_type_ff <= csi2_pkg::FRAME_START_RST;
         frame_end_type_ff   <= csi2_pkg::FRAME_END_RST;
         raw8_type_ff        <= csi2_pkg::RAW8_RST;
      end else if (csr_we) begin
         case (csr_index)
            csi2_pkg::REG_FRAME_START: frame_start_type_ff <= csr_wdata;
            csi2_pkg::REG_FRAME_END:   frame_end_type_ff   <= csr_wdata;
            csi2_pkg::REG_RAW8:        raw8_type_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Parse one stream byte: next parser state and optional result
   always_comb begin
      hdr_pos_in    = hdr_pos_ff;
      pkt_type_in   = pkt_type_ff;
      wc_high_in    = wc_high_ff;
      bytes_left_in = bytes_left_ff;
      in_frame_in   = in_frame_ff;
      frame_id_in   = frame_id_ff;
      res_have      = 1'b0;
      res.kind      = csi2_pkg::KIND_PAYLOAD;
      res.payload   = '0;
      res.frame_id  = '0;

      if (hdr_pos_ff == csi2_pkg::HDR_TYPE && bytes_left_ff != '0) begin
         // inside a long packet body: emit kept payload, skip CRC
         if (bytes_left_ff > csi2_pkg::CRC_BYTES && in_frame_ff
             && pkt_type_ff == raw8_type_ff) begin
            res_have     = 1'b1;
            res.kind     = csi2_pkg::KIND_PAYLOAD;
            res.payload  = in_byte;
            res.frame_id = frame_id_ff;
         end
         bytes_left_in = bytes_left_ff - csi2_pkg::COUNT_ONE;
      end else begin
         case (hdr_pos_ff)
            csi2_pkg::HDR_TYPE: begin
               pkt_type_in = in_byte;
               hdr_pos_in  = csi2_pkg::HDR_WC_HI;
            end
            csi2_pkg::HDR_WC_HI: begin
               wc_high_in = in_byte;
               hdr_pos_in = csi2_pkg::HDR_WC_LO;
            end
            csi2_pkg::HDR_WC_LO: begin
               bytes_left_in = {1'b0, wc_high_ff, in_byte};
               hdr_pos_in    = csi2_pkg::HDR_ECC;
            end
            default: begin
               // ECC byte: act on the completed header
               hdr_pos_in    = csi2_pkg::HDR_TYPE;
               bytes_left_in = '0;
               if (pkt_type_ff == frame_start_type_ff) begin
                  if (in_frame_ff) begin
                     res_have     = 1'b1;
                     res.kind     = csi2_pkg::KIND_ABANDON;
                     res.frame_id = frame_id_ff;
                  end
                  in_frame_in = 1'b1;
                  frame_id_in = word_count;
               end else if (pkt_type_ff == frame_end_type_ff) begin
                  if (in_frame_ff) begin
                     res_have     = 1'b1;
                     res.kind     = csi2_pkg::KIND_COMPLETE;
                     res.frame_id = frame_id_ff;
                     in_frame_in  = 1'b0;
                  end
               end else begin
                  bytes_left_in = {1'b0, word_count} + csi2_pkg::CRC_BYTES;
               end
            end
         endcase
      end

      // Buffer end: abandon an open frame, then return to reset state
      if (req_tlast) begin
         if (in_frame_in && !(res_have && res.kind == csi2_pkg::KIND_ABANDON)) begin
            res_have     = 1'b1;
            res.kind     = csi2_pkg::KIND_ABANDON;
            res.payload  = '0;
            res.frame_id = frame_id_in;
         end
         hdr_pos_in    = csi2_pkg::HDR_TYPE;
         pkt_type_in   = '0;
         wc_high_in    = '0;
         bytes_left_in = '0;
         in_frame_in   = 1'b0;
         frame_id_in   = '0;
      end
   end

   // Advance parser state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_pos_ff    <= csi2_pkg::HDR_TYPE;
         pkt_type_ff   <= '0;
         wc_high_ff    <= '0;
         bytes_left_ff <= '0;
         in_frame_ff   <= 1'b0;
         frame_id_ff   <= '0;
      end else if (accept) begin
         hdr_pos_ff    <= hdr_pos_in;
         pkt_type_ff   <= pkt_type_in;
         wc_high_ff    <= wc_high_in;
         bytes_left_ff <= bytes_left_in;
         in_frame_ff   <= in_frame_in;
         frame_id_ff   <= frame_id_in;
      end
   end

   // Stage results: output register first, skid register when it is held
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept && res_have) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (accept && res_have) begin
         if (!out_valid_ff || pop) begin
            out_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end
   end

   // Drive the result channel
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.frame_id, out_ff.payload};
   assign rsp_tuser  = out_ff.kind;

endmodule
